// ----- rtl/core/cda_pkg.sv -----
// Package for the calendar date arithmetic unit: payload structs, codes,
// month tables and small date helpers. No dependencies.
package cda_pkg;

    localparam int unsigned MaxSerial = 3652058;

    // register stages from input transfer to the output register
    localparam int PipeDepth = 8;

    typedef enum logic [2:0] {
        CMD_ADD  = 3'd0,
        CMD_SUB  = 3'd1,
        CMD_DIFF = 3'd2,
        CMD_NEXT = 3'd3,
        CMD_PREV = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BAD   = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [15:0] day_count;
        logic [13:0] other_year;
        logic [3:0]  other_month;
        logic [4:0]  other_day;
    } in_item_t;

    typedef struct packed {
        logic [13:0] result_year;
        logic [3:0]  result_month;
        logic [4:0]  result_day;
        logic [21:0] day_difference;
        logic [1:0]  status;
    } out_item_t;

    // v / 100 by reciprocal multiply; exact for every 14-bit v, the result
    // wraps above 12799, which only out-of-range years reach
    function automatic logic [6:0] div100(input logic [13:0] v);
        logic [26:0] prod;
        prod = 27'(v) * 27'd5243;
        return 7'(prod >> 19);
    endfunction

    // leap flag from a year split into century and low part (y = c*100 + r)
    function automatic logic leap_cr(input logic [6:0] c, input logic [6:0] r);
        if (r == 7'd0) return (c[1:0] == 2'b00);
        return (r[1:0] == 2'b00);
    endfunction

    function automatic logic [4:0] month_len(input logic lp, input logic [3:0] m);
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
            4'd2: return lp ? 5'd29 : 5'd28;
            default: return 5'd0;
        endcase
    endfunction

    // days before the first of month m
    function automatic logic [8:0] month_start(input logic lp, input logic [3:0] m);
        logic [8:0] v;
        case (m)
            4'd1: v = 9'd0;    4'd2: v = 9'd31;   4'd3: v = 9'd59;
            4'd4: v = 9'd90;   4'd5: v = 9'd120;  4'd6: v = 9'd151;
            4'd7: v = 9'd181;  4'd8: v = 9'd212;  4'd9: v = 9'd243;
            4'd10: v = 9'd273; 4'd11: v = 9'd304; 4'd12: v = 9'd334;
            default: v = 9'd0;
        endcase
        if (lp && m > 4'd2) v = v + 9'd1;
        return v;
    endfunction

endpackage

// ----- rtl/core/cda_to_serial.sv -----
// Date to day serial pipeline (three register stages) with validity check.
// Depends on cda_pkg.
module cda_to_serial (
    input  logic        aclk,
    input  logic        en,
    input  logic [13:0] year,
    input  logic [3:0]  month,
    input  logic [4:0]  day,
    output logic        ok,
    output logic [21:0] serial
);

    // stage 1: split year-1 into century and remainder, day of year, check date
    logic [6:0]  c1_reg, r1_reg;
    logic [8:0]  doy1_reg;
    logic        ok1_reg;
    logic [13:0] p;
    logic [6:0]  cy, ry, pc, pr;
    logic        lp;

    always_comb begin
        p  = year - 14'd1;
        cy = cda_pkg::div100(year);
        ry = 7'(year - 14'(cy) * 14'd100);
        pc = cda_pkg::div100(p);
        pr = 7'(p - 14'(pc) * 14'd100);
        lp = cda_pkg::leap_cr(cy, ry);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c1_reg   <= pc;
            r1_reg   <= pr;
            doy1_reg <= cda_pkg::month_start(lp, month) + 9'(day) - 9'd1;
            ok1_reg  <= year >= 14'd1 && year <= 14'd9999 && month >= 4'd1
                        && month <= 4'd12 && day >= 5'd1
                        && day <= cda_pkg::month_len(lp, month);
        end
    end

    // stage 2: days in whole centuries and whole years of the current one
    logic [21:0] cd2_reg;
    logic [15:0] yd2_reg;
    logic [8:0]  doy2_reg;
    logic        ok2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            cd2_reg  <= 22'(c1_reg) * 22'd36524 + 22'(c1_reg[6:2]);
            yd2_reg  <= 16'(r1_reg) * 16'd365 + 16'(r1_reg[6:2]);
            doy2_reg <= doy1_reg;
            ok2_reg  <= ok1_reg;
        end
    end

    // stage 3: sum
    logic [21:0] s3_reg;
    logic        ok3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_reg  <= cd2_reg + 22'(yd2_reg) + 22'(doy2_reg);
            ok3_reg <= ok2_reg;
        end
    end

    assign ok     = ok3_reg;
    assign serial = s3_reg;

endmodule

// ----- rtl/core/cda_from_serial.sv -----
// Day serial to date pipeline (three register stages).
// Depends on cda_pkg.
module cda_from_serial (
    input  logic        aclk,
    input  logic        en,
    input  logic [21:0] serial,
    output logic [13:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day
);

    // stage 1: 400-year cycles via reciprocal, then correction
    logic [4:0]  q400_1_reg;
    logic [17:0] r400_1_reg;
    logic [4:0]  qe;
    logic [22:0] re;

    always_comb begin
        qe = 5'((44'(serial) * 44'd117592) >> 34);
        re = 23'(serial) - 23'(qe) * 23'd146097;
        if (re >= 23'd146097) begin
            qe = qe + 5'd1;
            re = re - 23'd146097;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q400_1_reg <= qe;
            r400_1_reg <= 18'(re);
        end
    end

    // stage 2: centuries, then 4-year blocks, then years
    logic [13:0] yb2_reg;
    logic [8:0]  doy2_reg;
    logic [1:0]  q100;
    logic [17:0] r1;
    logic [5:0]  q4;
    logic [11:0] r2;
    logic [1:0]  q1;
    logic [10:0] r3;

    always_comb begin
        if (r400_1_reg >= 18'd109572)     q100 = 2'd3;
        else if (r400_1_reg >= 18'd73048) q100 = 2'd2;
        else if (r400_1_reg >= 18'd36524) q100 = 2'd1;
        else                              q100 = 2'd0;
        r1 = r400_1_reg - 18'(q100) * 18'd36524;
        // reciprocal estimate is low by at most one
        q4 = 6'((22'(r1) * 22'd44) >> 16);
        r2 = 12'(r1 - 18'(q4) * 18'd1461);
        if (r2 >= 12'd1461) begin
            q4 = q4 + 6'd1;
            r2 = r2 - 12'd1461;
        end
        if (r2 >= 12'd1095)     q1 = 2'd3;
        else if (r2 >= 12'd730) q1 = 2'd2;
        else if (r2 >= 12'd365) q1 = 2'd1;
        else                    q1 = 2'd0;
        r3 = 11'(r2 - 12'(q1) * 12'd365);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            yb2_reg  <= 14'(q400_1_reg) * 14'd400 + 14'(q100) * 14'd100
                        + 14'(q4) * 14'd4 + 14'(q1) + 14'd1;
            doy2_reg <= 9'(r3);
        end
    end

    // stage 3: month lookup
    logic [13:0] y3_reg;
    logic [3:0]  m3_reg;
    logic [4:0]  d3_reg;
    logic [6:0]  cy, ry;
    logic        lp;
    logic [3:0]  mo;

    always_comb begin
        cy = cda_pkg::div100(yb2_reg);
        ry = 7'(yb2_reg - 14'(cy) * 14'd100);
        lp = cda_pkg::leap_cr(cy, ry);
        mo = 4'd1;
        for (int i = 2; i <= 12; i++) begin
            if (doy2_reg >= cda_pkg::month_start(lp, 4'(i))) mo = 4'(i);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            y3_reg <= yb2_reg;
            m3_reg <= mo;
            d3_reg <= 5'(doy2_reg - cda_pkg::month_start(lp, mo) + 9'd1);
        end
    end

    assign year  = y3_reg;
    assign month = m3_reg;
    assign day   = d3_reg;

endmodule

// ----- rtl/core/calendar_date_arithmetic_unit.sv -----
// One item per cycle sustained while m_ready stays high.
// Stages: 3 date-to-serial, 1 add/subtract/compare, 3 serial-to-date, 1 output.
// The pipeline advances whenever its last stage is empty or being taken.
// Reset (aresetn, synchronous, active low) clears all valid bits only.
// Depends on cda_pkg, cda_to_serial and cda_from_serial.
module calendar_date_arithmetic_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cda_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output cda_pkg::out_item_t  m_data
);

    logic                          adv;
    logic [cda_pkg::PipeDepth-1:0] vld_reg;

    assign adv     = !vld_reg[cda_pkg::PipeDepth-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[cda_pkg::PipeDepth-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[cda_pkg::PipeDepth-2:0], s_valid};
        end
    end

    // side data through the conversion stages
    logic [2:0]  cmd_reg [3];
    logic [15:0] cnt_reg [3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            cmd_reg[0] <= s_data.command;
            cnt_reg[0] <= s_data.day_count;
            for (int i = 1; i < 3; i++) begin
                cmd_reg[i] <= cmd_reg[i-1];
                cnt_reg[i] <= cnt_reg[i-1];
            end
        end
    end

    logic        ok_a, ok_b;
    logic [21:0] ser_a, ser_b;

    cda_to_serial u_ser_a (
        .aclk(aclk), .en(adv), .year(s_data.year), .month(s_data.month),
        .day(s_data.day), .ok(ok_a), .serial(ser_a)
    );

    cda_to_serial u_ser_b (
        .aclk(aclk), .en(adv), .year(s_data.other_year),
        .month(s_data.other_month), .day(s_data.other_day),
        .ok(ok_b), .serial(ser_b)
    );

    // arithmetic stage
    logic [21:0] sr_reg, diff_reg;
    logic [1:0]  st_reg;
    logic        date_reg;
    logic [21:0] sr_n, diff_n;
    logic [1:0]  st_n;
    logic        date_n;
    logic [22:0] sum;

    always_comb begin
        sr_n   = ser_a;
        diff_n = '0;
        st_n   = cda_pkg::ST_OK;
        date_n = 1'b0;
        sum    = '0;
        if (!ok_a) begin
            st_n = cda_pkg::ST_BAD;
        end else begin
            unique case (cmd_reg[2]) inside
                cda_pkg::CMD_ADD, cda_pkg::CMD_NEXT: begin
                    sum = 23'(ser_a) + ((cmd_reg[2] == cda_pkg::CMD_ADD)
                          ? 23'(cnt_reg[2]) : 23'd1);
                    if (sum > 23'(cda_pkg::MaxSerial)) st_n = cda_pkg::ST_RANGE;
                    else begin
                        sr_n = 22'(sum); date_n = 1'b1;
                    end
                end
                cda_pkg::CMD_SUB, cda_pkg::CMD_PREV: begin
                    sum = 23'(ser_a) - ((cmd_reg[2] == cda_pkg::CMD_SUB)
                          ? 23'(cnt_reg[2]) : 23'd1);
                    if (sum[22]) st_n = cda_pkg::ST_RANGE;
                    else begin
                        sr_n = 22'(sum); date_n = 1'b1;
                    end
                end
                cda_pkg::CMD_DIFF: begin
                    if (!ok_b) st_n = cda_pkg::ST_BAD;
                    else diff_n = (ser_a > ser_b) ? ser_a - ser_b : ser_b - ser_a;
                end
                default: st_n = cda_pkg::ST_BAD;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sr_reg   <= sr_n;
            diff_reg <= diff_n;
            st_reg   <= st_n;
            date_reg <= date_n;
        end
    end

    logic [13:0] fy;
    logic [3:0]  fm;
    logic [4:0]  fd;

    cda_from_serial u_date (
        .aclk(aclk), .en(adv), .serial(sr_reg), .year(fy), .month(fm), .day(fd)
    );

    logic [21:0] diff_d_reg [3];
    logic [1:0]  st_d_reg [3];
    logic        date_d_reg [3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            diff_d_reg[0] <= diff_reg;
            st_d_reg[0]   <= st_reg;
            date_d_reg[0] <= date_reg;
            for (int i = 1; i < 3; i++) begin
                diff_d_reg[i] <= diff_d_reg[i-1];
                st_d_reg[i]   <= st_d_reg[i-1];
                date_d_reg[i] <= date_d_reg[i-1];
            end
        end
    end

    cda_pkg::out_item_t out_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg.result_year    <= date_d_reg[2] ? fy : '0;
            out_reg.result_month   <= date_d_reg[2] ? fm : '0;
            out_reg.result_day     <= date_d_reg[2] ? fd : '0;
            out_reg.day_difference <= diff_d_reg[2];
            out_reg.status         <= st_d_reg[2];
        end
    end

    assign m_data = out_reg;

endmodule

// ----- rtl/core/cda_checker.sv -----
// Port-level checker for the calendar date arithmetic unit, bound to the top.
// Depends on cda_pkg and calendar_date_arithmetic_unit.
module cda_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input cda_pkg::out_item_t m_data
);

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty output");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status == cda_pkg::ST_OK
                    || m_data.status == cda_pkg::ST_BAD
                    || m_data.status == cda_pkg::ST_RANGE)
        else $error("bad status code");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != cda_pkg::ST_OK |->
        m_data.result_year == 14'd0 && m_data.day_difference == 22'd0)
        else $error("nonzero fields on error");

endmodule

bind calendar_date_arithmetic_unit cda_checker u_cda_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
